### hdl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on the rising clock edge, off while reset is active.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Implication checked on the rising clock edge, off while reset is active.
`define ASSERT_IMPL(lbl, pre, post, msg) \
	`ASSERT_CLK(lbl, (pre) |=> (post), msg)

`endif

### hdl/dcfb_pkg.sv
package dcfb_pkg;

	// Action codes of an input item.
	localparam logic ACT_MOVE = 1'b0;
	localparam logic ACT_SEND = 1'b1;

	// Direction codes; every other code means stop.
	localparam logic [2:0] DIR_FWD   = 3'd0;
	localparam logic [2:0] DIR_LEFT  = 3'd1;
	localparam logic [2:0] DIR_RIGHT = 3'd2;
	localparam logic [2:0] DIR_BACK  = 3'd3;

	// Drive bits for each direction.
	localparam logic [7:0] BITS_FWD   = 8'b0101_0000;
	localparam logic [7:0] BITS_LEFT  = 8'b0001_0000;
	localparam logic [7:0] BITS_RIGHT = 8'b0100_0000;
	localparam logic [7:0] BITS_BACK  = 8'b0000_0000;
	localparam logic [7:0] BITS_STOP  = 8'b0101_0000;

	// Fixed frame bytes and the frame check constants.
	localparam logic [7:0]  START_BYTE  = 8'hFF;
	localparam logic [7:0]  LENGTH_BYTE = 8'h07;
	localparam logic [7:0]  PAD_BYTE    = 8'h00;
	localparam logic [15:0] CRC_INIT    = 16'hFFFF;
	localparam logic [15:0] CRC_POLY    = 16'hA001;

	// Position of a byte within the frame.
	typedef logic [3:0] byte_idx_t;

	localparam byte_idx_t IDX_START = 4'd0;
	localparam byte_idx_t IDX_LEN   = 4'd1;
	localparam byte_idx_t IDX_SPD_L = 4'd2;
	localparam byte_idx_t IDX_PAD_L = 4'd3;
	localparam byte_idx_t IDX_SPD_R = 4'd4;
	localparam byte_idx_t IDX_PAD_R = 4'd5;
	localparam byte_idx_t IDX_BITS  = 4'd6;
	localparam byte_idx_t IDX_CRC_L = 4'd7;
	localparam byte_idx_t IDX_CRC_H = 4'd8;

	// Send request from the command stage to the transmitter.
	typedef struct packed {
		logic       req;
		logic [7:0] speed;
		logic [7:0] bits;
	} send_req_t;

	// One byte step of the reflected CRC-16/MODBUS.
	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

### hdl/dcfb_cmd.sv
module dcfb_cmd (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                action,
	input  logic [2:0]          direction,
	input  logic [7:0]          speed,
	input  logic                tx_ready,
	output dcfb_pkg::send_req_t send_req
);
	import dcfb_pkg::*;

	logic       valid_s1;
	logic       action_s1;
	logic [2:0] direction_s1;
	logic [7:0] speed_s1;
	logic [7:0] wheel_speed_q;
	logic [7:0] drive_bits_q;
	logic       advance;
	logic       accept;

	// The held item leaves when it is a move or the transmitter takes the send.
	assign advance  = valid_s1 && ((action_s1 == ACT_MOVE) || tx_ready);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	// Input register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1    <= action;
			direction_s1 <= direction;
			speed_s1     <= speed;
		end
	end

	// A move item updates the stored drive command.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wheel_speed_q <= 8'h00;
			drive_bits_q  <= 8'h00;
		end else if (valid_s1 && (action_s1 == ACT_MOVE)) begin
			case (direction_s1)
				DIR_FWD: begin
					wheel_speed_q <= speed_s1;
					drive_bits_q  <= BITS_FWD;
				end
				DIR_LEFT: begin
					wheel_speed_q <= speed_s1;
					drive_bits_q  <= BITS_LEFT;
				end
				DIR_RIGHT: begin
					wheel_speed_q <= speed_s1;
					drive_bits_q  <= BITS_RIGHT;
				end
				DIR_BACK: begin
					wheel_speed_q <= speed_s1;
					drive_bits_q  <= BITS_BACK;
				end
				default: begin
					wheel_speed_q <= 8'h00;
					drive_bits_q  <= BITS_STOP;
				end
			endcase
		end
	end

	// A send item hands a snapshot of the command to the transmitter.
	always_comb begin
		send_req.req   = valid_s1 && (action_s1 == ACT_SEND);
		send_req.speed = wheel_speed_q;
		send_req.bits  = drive_bits_q;
	end

endmodule

### hdl/dcfb_tx.sv
module dcfb_tx (
	input  logic                clk,
	input  logic                arst_n,
	input  dcfb_pkg::send_req_t send_req,
	output logic                tx_ready,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [7:0]          frame_byte,
	output logic                last_byte
);
	import dcfb_pkg::*;

	logic        out_valid_q;
	byte_idx_t   idx_q;
	logic [7:0]  byte_q;
	logic [7:0]  spd_q;
	logic [7:0]  bits_q;
	logic [15:0] crc_q;
	logic        is_last;
	logic        xfer;
	logic        load;
	byte_idx_t   idx_next;
	logic [7:0]  byte_next;

	assign is_last  = (idx_q == IDX_CRC_H);
	assign xfer     = out_valid_q && !out_stall;
	assign tx_ready = !out_valid_q || (is_last && !out_stall);
	assign load     = send_req.req && tx_ready;
	assign idx_next = idx_q + 4'd1;

	// Select the frame byte that follows the one on the output.
	always_comb begin
		case (idx_next)
			IDX_LEN:            byte_next = LENGTH_BYTE;
			IDX_SPD_L, IDX_SPD_R: byte_next = spd_q;
			IDX_PAD_L, IDX_PAD_R: byte_next = PAD_BYTE;
			IDX_BITS:           byte_next = bits_q;
			IDX_CRC_L:          byte_next = crc_q[7:0];
			IDX_CRC_H:          byte_next = crc_q[15:8];
			default:            byte_next = START_BYTE;
		endcase
	end

	// Output control: a new frame starts when the previous one has left.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= IDX_START;
		end else if (load) begin
			out_valid_q <= 1'b1;
			idx_q       <= IDX_START;
		end else if (xfer) begin
			if (is_last) begin
				out_valid_q <= 1'b0;
			end else begin
				idx_q <= idx_next;
			end
		end
	end

	// Output byte, command snapshot and the check, fed the length to drive-bits bytes one per transfer.
	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= START_BYTE;
			spd_q  <= send_req.speed;
			bits_q <= send_req.bits;
			crc_q  <= CRC_INIT;
		end else if (xfer && !is_last) begin
			byte_q <= byte_next;
			if (idx_next inside {[IDX_LEN:IDX_BITS]}) begin
				crc_q <= crc_feed(crc_q, byte_next);
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign frame_byte = byte_q;
	assign last_byte  = out_valid_q && is_last;

endmodule

### hdl/drive_command_frame_builder.sv
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_stall  | action, direction, speed
// out     | output    | out_valid/out_stall| frame_byte, last_byte
//
// A move item never waits in the input register; items enter back to back through it.
// A send item yields nine bytes, one per unstalled cycle, from the output register.
// Moves behind a send keep flowing; a second send waits until the frame's last byte leaves.
// The check takes the length to drive-bits bytes, one per transfer, eight CRC steps each.
// Reset clears the command to zero speed and zero drive bits and empties both registers.
module drive_command_frame_builder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       action,
	input  logic [2:0] direction,
	input  logic [7:0] speed,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] frame_byte,
	output logic       last_byte
);
	import dcfb_pkg::*;

	send_req_t send_req;
	logic      tx_ready;

	// Command register and direction decode.
	dcfb_cmd u_cmd (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.action    (action),
		.direction (direction),
		.speed     (speed),
		.tx_ready  (tx_ready),
		.send_req  (send_req)
	);

	// Frame serializer with the running check.
	dcfb_tx u_tx (
		.clk        (clk),
		.arst_n     (arst_n),
		.send_req   (send_req),
		.tx_ready   (tx_ready),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.frame_byte (frame_byte),
		.last_byte  (last_byte)
	);

endmodule

### hdl/dcfb_checker.sv
`include "assert_macros.svh"

module dcfb_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] frame_byte,
	input logic       last_byte
);

	// A stalled output byte holds.
	`ASSERT_IMPL(a_out_hold, out_valid && out_stall, out_valid && $stable(frame_byte) && $stable(last_byte), "stalled output changed")

	// Bytes of one frame follow without a gap.
	`ASSERT_IMPL(a_frame_contig, out_valid && !out_stall && !last_byte, out_valid, "gap inside a frame")

	// The last byte is never followed directly by another last byte.
	`ASSERT_IMPL(a_single_last, out_valid && !out_stall && last_byte, !out_valid || !last_byte, "two last bytes in a row")

	// A frame that follows at once starts with the start byte.
	`ASSERT_IMPL(a_next_start, out_valid && !out_stall && last_byte, !out_valid || (frame_byte == 8'hFF), "frame does not open with start byte")

endmodule

bind drive_command_frame_builder dcfb_checker u_dcfb_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.frame_byte (frame_byte),
	.last_byte  (last_byte)
);

### sim/tb_drive_command_frame_builder.sv
module tb_drive_command_frame_builder;
	import dcfb_pkg::*;

	// Direction codes that all mean stop.
	localparam logic [2:0] DIR_STOP     = 3'd4;
	localparam logic [2:0] DIR_SPARE_5  = 3'd5;
	localparam logic [2:0] DIR_SPARE_6  = 3'd6;
	localparam logic [2:0] DIR_SPARE_7  = 3'd7;

	localparam int unsigned FRAME_BYTES  = 9;
	localparam int unsigned RANDOM_ITEMS = 246;
	localparam int unsigned CYCLE_LIMIT  = 400000;

	// One expected byte on the output channel.
	typedef struct {
		logic [7:0] value;
		logic       last;
	} frame_beat_t;

	// One directed command; typed rows carry the speed and drive bits the frame must show.
	typedef struct {
		logic       act;
		logic [2:0] dir;
		logic [7:0] spd;
		logic       typed;
		logic [7:0] t_speed;
		logic [7:0] t_bits;
	} command_row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic       action = ACT_MOVE;
	logic [2:0] direction = DIR_FWD;
	logic [7:0] speed = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] frame_byte;
	logic       last_byte;

	// Predicted command state.
	logic [7:0]  cmd_speed;
	logic [7:0]  cmd_bits;
	frame_beat_t pending_bytes[$];

	int unsigned error_count = 0;
	int unsigned cycle_count = 0;
	int unsigned stall_hold = 0;
	logic        no_idle = 1'b0;

	command_row_t directed_rows[24];

	drive_command_frame_builder dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.action     (action),
		.direction  (direction),
		.speed      (speed),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.frame_byte (frame_byte),
		.last_byte  (last_byte)
	);

	always #10 clk = ~clk;

	// Reflected CRC-16 update by one byte, shifting out the low bit each step.
	function automatic logic [15:0] modbus_crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] acc;
		acc = crc ^ {8'h00, b};
		repeat (8) begin
			acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
		end
		return acc;
	endfunction

	// Check over the frame bytes between the start byte and the check bytes.
	function automatic logic [15:0] frame_crc(input logic [7:0] spd, input logic [7:0] bits);
		logic [7:0]  body[6];
		logic [15:0] acc;
		body = '{LENGTH_BYTE, spd, PAD_BYTE, spd, PAD_BYTE, bits};
		acc = CRC_INIT;
		foreach (body[i]) begin
			acc = modbus_crc_byte(acc, body[i]);
		end
		return acc;
	endfunction

	// Queue the nine bytes that a send transfer must produce.
	function automatic void queue_frame(input logic [7:0] spd, input logic [7:0] bits);
		logic [15:0] crc;
		logic [7:0]  bytes[FRAME_BYTES];
		frame_beat_t beat;
		crc = frame_crc(spd, bits);
		bytes = '{START_BYTE, LENGTH_BYTE, spd, PAD_BYTE, spd, PAD_BYTE, bits,
			crc[7:0], crc[15:8]};
		foreach (bytes[i]) begin
			beat.value = bytes[i];
			beat.last = (i == FRAME_BYTES - 1);
			pending_bytes.push_back(beat);
		end
	endfunction

	// A move transfer replaces the stored command; stop and unknown codes zero the speed.
	function automatic void apply_move(input logic [2:0] dir, input logic [7:0] spd);
		cmd_speed = spd;
		case (dir)
			DIR_FWD: begin
				cmd_bits = BITS_FWD;
			end
			DIR_LEFT: begin
				cmd_bits = BITS_LEFT;
			end
			DIR_RIGHT: begin
				cmd_bits = BITS_RIGHT;
			end
			DIR_BACK: begin
				cmd_bits = BITS_BACK;
			end
			default: begin
				cmd_speed = 8'h00;
				cmd_bits = BITS_STOP;
			end
		endcase
	endfunction

	// Idle length: mostly none or short, now and then long.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 50) begin
			return 0;
		end else if (r < 88) begin
			return $urandom_range(1, 3);
		end else begin
			return $urandom_range(8, 30);
		end
	endfunction

	task automatic report_mismatch(input string what);
		error_count++;
		$display("[%0d] mismatch: %s", cycle_count, what);
	endtask

	// Present one command, wait for its transfer, then update the prediction.
	task automatic drive_command(input logic act, input logic [2:0] dir, input logic [7:0] spd,
		input logic typed, input logic [7:0] t_speed, input logic [7:0] t_bits);
		int unsigned gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		direction <= dir;
		speed <= spd;
		@(posedge clk);
		while (in_stall !== 1'b0) @(posedge clk);
		if (act == ACT_SEND) begin
			if (typed) begin
				queue_frame(t_speed, t_bits);
			end else begin
				queue_frame(cmd_speed, cmd_bits);
			end
		end else begin
			apply_move(dir, spd);
		end
	endtask

	// Wait until no expected byte is left, stepping the clock before each check.
	task automatic drain_frames();
		do begin
			@(posedge clk);
		end while (pending_bytes.size() != 0);
	endtask

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Receiver stall: short bursts mostly, a few long ones, none in quiet stretches.
	always @(posedge clk) begin
		if (stall_hold > 0) begin
			stall_hold <= stall_hold - 1;
		end else if (!no_idle && $urandom_range(0, 99) < 30) begin
			out_stall <= 1'b1;
			stall_hold <= ($urandom_range(0, 9) != 0) ? $urandom_range(0, 2) : $urandom_range(10, 40);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Compare every output transfer with the oldest expected byte.
	always @(posedge clk) begin
		frame_beat_t want;
		if (arst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
			if (pending_bytes.size() == 0) begin
				report_mismatch($sformatf("unexpected byte %02h", frame_byte));
			end else begin
				want = pending_bytes.pop_front();
				if (frame_byte !== want.value) begin
					report_mismatch($sformatf("frame_byte %02h, expected %02h",
						frame_byte, want.value));
				end
				if (last_byte !== want.last) begin
					report_mismatch($sformatf("last_byte %0b, expected %0b",
						last_byte, want.last));
				end
			end
		end
	end

	initial begin
		int unsigned r;
		logic [2:0]  dir;
		logic [7:0]  spd;

		// Extremes of speed, every direction code, sends after reset, back to back
		// moves and sends, and a move following right behind a send.
		directed_rows = '{
			'{ACT_SEND, DIR_FWD,     8'h00, 1'b1, 8'h00, BITS_BACK},
			'{ACT_MOVE, DIR_FWD,     8'hFF, 1'b0, 8'h00, 8'h00},
			'{ACT_SEND, DIR_FWD,     8'h00, 1'b1, 8'hFF, BITS_FWD},
			'{ACT_MOVE, DIR_LEFT,    8'h80, 1'b0, 8'h00, 8'h00},
			'{ACT_SEND, DIR_LEFT,    8'hFF, 1'b1, 8'h80, BITS_LEFT},
			'{ACT_MOVE, DIR_RIGHT,   8'h01, 1'b0, 8'h00, 8'h00},
			'{ACT_SEND, DIR_SPARE_7, 8'h5A, 1'b1, 8'h01, BITS_RIGHT},
			'{ACT_MOVE, DIR_BACK,    8'h7F, 1'b0, 8'h00, 8'h00},
			'{ACT_SEND, DIR_BACK,    8'h00, 1'b1, 8'h7F, BITS_BACK},
			'{ACT_MOVE, DIR_STOP,    8'hAA, 1'b0, 8'h00, 8'h00},
			'{ACT_SEND, DIR_FWD,     8'h00, 1'b1, 8'h00, BITS_STOP},
			'{ACT_MOVE, DIR_SPARE_7, 8'hFF, 1'b0, 8'h00, 8'h00},
			'{ACT_SEND, DIR_FWD,     8'h00, 1'b1, 8'h00, BITS_STOP},
			'{ACT_MOVE, DIR_SPARE_5, 8'h55, 1'b0, 8'h00, 8'h00},
			'{ACT_MOVE, DIR_FWD,     8'h33, 1'b0, 8'h00, 8'h00},
			'{ACT_SEND, DIR_FWD,     8'h00, 1'b0, 8'h00, 8'h00},
			'{ACT_MOVE, DIR_SPARE_6, 8'h01, 1'b0, 8'h00, 8'h00},
			'{ACT_SEND, DIR_FWD,     8'h00, 1'b1, 8'h00, BITS_STOP},
			'{ACT_SEND, DIR_FWD,     8'h00, 1'b1, 8'h00, BITS_STOP},
			'{ACT_MOVE, DIR_FWD,     8'h00, 1'b0, 8'h00, 8'h00},
			'{ACT_SEND, DIR_FWD,     8'h00, 1'b1, 8'h00, BITS_FWD},
			'{ACT_MOVE, DIR_BACK,    8'h12, 1'b0, 8'h00, 8'h00},
			'{ACT_SEND, DIR_FWD,     8'h00, 1'b1, 8'h12, BITS_BACK},
			'{ACT_MOVE, DIR_LEFT,    8'hC3, 1'b0, 8'h00, 8'h00}
		};

		// The command after reset is zero speed with zero drive bits.
		cmd_speed = 8'h00;
		cmd_bits = BITS_BACK;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			drive_command(directed_rows[i].act, directed_rows[i].dir, directed_rows[i].spd,
				directed_rows[i].typed, directed_rows[i].t_speed, directed_rows[i].t_bits);
		end

		// Hold the sender until every frame so far has been received.
		in_valid <= 1'b0;
		drain_frames();

		// Random commands, in stretches picked at random to be quiet or to idle.
		for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 40 == 0) begin
				no_idle = ($urandom_range(0, 3) == 0);
			end
			if (n == RANDOM_ITEMS / 2) begin
				in_valid <= 1'b0;
				drain_frames();
			end
			r = $urandom_range(0, 99);
			if (r < 55) begin
				dir = 3'(($urandom_range(0, 99) < 85) ? $urandom_range(0, 3)
					: $urandom_range(4, 7));
				spd = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? 8'hFF : 8'h00)
					: 8'($urandom_range(0, 255));
				drive_command(ACT_MOVE, dir, spd, 1'b0, 8'h00, 8'h00);
			end else begin
				drive_command(ACT_SEND, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
					1'b0, 8'h00, 8'h00);
			end
		end
		in_valid <= 1'b0;
		no_idle = 1'b0;

		// Let every frame come out, then give stray bytes a chance to show.
		drain_frames();
		repeat (30) @(posedge clk);

		if (error_count == 0 && pending_bytes.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
